// ===== design/assert_macros.svh =====
// Assertion macros for the queue design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int OP_W            = 2;
    localparam int ID_W            = 8;
    localparam int PR_W            = 8;
    localparam int STATUS_W        = 2;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 24;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } spq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE = 2'd0,
        STS_MISS = 2'd1,
        STS_FULL = 2'd2
    } spq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WORK,
        ST_ROT
    } spq_state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_SHIFT,
        CELL_ROTATE
    } spq_cell_cmd_t;

    typedef struct packed {
        spq_cell_cmd_t   cmd;
        logic [ID_W-1:0] new_id;
        logic [PR_W-1:0] new_pr;
        logic            keep;
    } spq_cell_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// One slot of the queue row: holds an id and priority pair and trades with its neighbours.
module spq_cell #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX         = 0
) (
    input  logic                          aclk,
    input  spq_pkg::spq_cell_ctrl_t       ctrl,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
    input  logic                          left_stays,
    input  logic [spq_pkg::ID_W-1:0]      left_id,
    input  logic [spq_pkg::PR_W-1:0]      left_pr,
    input  logic [spq_pkg::ID_W-1:0]      right_id,
    input  logic [spq_pkg::PR_W-1:0]      right_pr,
    input  logic [spq_pkg::ID_W-1:0]      head_id,
    input  logic [spq_pkg::PR_W-1:0]      head_pr,
    output logic                          stays,
    output logic [spq_pkg::ID_W-1:0]      slot_id,
    output logic [spq_pkg::PR_W-1:0]      slot_pr
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [spq_pkg::ID_W-1:0] id_reg, id_next;
    logic [spq_pkg::PR_W-1:0] pr_reg, pr_next;
    logic                     occupied;
    logic                     tail_hit;

    assign occupied = CW'(IDX) < count;
    assign tail_hit = CW'(IDX + 1) == count;
    // Entry of equal or better priority keeps its place on a push.
    assign stays    = occupied && (pr_reg <= ctrl.new_pr);

    always_comb begin
        id_next = id_reg;
        pr_next = pr_reg;
        case (ctrl.cmd)
            spq_pkg::CELL_PUSH: begin
                if (!stays) begin
                    if (left_stays) begin
                        id_next = ctrl.new_id;
                        pr_next = ctrl.new_pr;
                    end else begin
                        id_next = left_id;
                        pr_next = left_pr;
                    end
                end
            end
            spq_pkg::CELL_SHIFT: begin
                id_next = right_id;
                pr_next = right_pr;
            end
            spq_pkg::CELL_ROTATE: begin
                if (tail_hit && ctrl.keep) begin
                    id_next = head_id;
                    pr_next = head_pr;
                end else begin
                    id_next = right_id;
                    pr_next = right_pr;
                end
            end
            default: begin
                id_next = id_reg;
                pr_next = pr_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
        pr_reg <= pr_next;
    end

    assign slot_id = id_reg;
    assign slot_pr = pr_reg;

endmodule

// ===== design/stable_priority_queue_remove_by_id_core.sv =====
// Top level of the stable sorted priority queue with removal by task id.
//
// Ready queue for a scheduler: a row of QUEUE_DEPTH cells, slot 0 the head, kept
// sorted by priority (lower first, equal priorities in arrival order).
// Requests arrive on the s_ channel (operation, task id, priority); each gives
// exactly one result on the m_ channel (status, id, priority, queue empty).
// Push: every cell compares its priority with the new one in parallel and either
//   holds, takes the new entry or takes its left neighbour.
// Pop: every cell takes its right neighbour.
// Remove: the row rotates once through the head, one entry per cycle unless the
//   final step waits for the output register; the first entry with a matching id
//   is dropped and reported, the rest return to their order.
// A request is taken only while the block is idle; the result sits in an output
// register, so the next request is taken while a result still waits.
// If the receiver stalls, the final step of the next request holds until the
// output register frees up.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared and are never read while unoccupied.
`include "assert_macros.svh"

module stable_priority_queue_remove_by_id_core #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] operation, [9:2] task_id, [17:10] priority_req, [23:18] zero
    input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [9:2] out_task_id, [17:10] out_priority, [18] queue_empty,
    // [23:19] zero
    output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W = spq_pkg::ID_W;
    localparam int PR_W = spq_pkg::PR_W;

    // Control and request state
    spq_pkg::spq_state_t  state_reg, state_next;
    spq_pkg::spq_op_t     req_op_reg, req_op_next;
    logic [ID_W-1:0]      req_id_reg, req_id_next;
    logic [PR_W-1:0]      req_pr_reg, req_pr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        steps_reg, steps_next;
    logic                 found_reg, found_next;
    logic [ID_W-1:0]      found_id_reg, found_id_next;
    logic [PR_W-1:0]      found_pr_reg, found_pr_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    spq_pkg::spq_status_t out_status_reg, out_status_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [PR_W-1:0]      out_pr_reg, out_pr_next;
    logic                 out_empty_reg, out_empty_next;

    logic                 s_accept;
    logic                 out_free;
    logic                 head_keep;
    spq_pkg::spq_cell_ctrl_t cell_ctrl;

    // Cell row taps
    logic [ID_W-1:0]      slot_id [QUEUE_DEPTH];
    logic [PR_W-1:0]      slot_pr [QUEUE_DEPTH];
    logic                 slot_stays [QUEUE_DEPTH];

    assign s_tready = state_reg == spq_pkg::ST_IDLE;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    // Drop the head only if it is the first match seen during this rotation.
    assign head_keep = found_reg || (slot_id[0] != req_id_reg);

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            logic            l_stays;
            logic [ID_W-1:0] l_id, r_id;
            logic [PR_W-1:0] l_pr, r_pr;

            if (i == 0) begin : g_first
                assign l_stays = 1'b1;
                assign l_id    = slot_id[i];
                assign l_pr    = slot_pr[i];
            end else begin : g_inner_l
                assign l_stays = slot_stays[i-1];
                assign l_id    = slot_id[i-1];
                assign l_pr    = slot_pr[i-1];
            end

            if (i == QUEUE_DEPTH - 1) begin : g_last
                assign r_id = slot_id[i];
                assign r_pr = slot_pr[i];
            end else begin : g_inner_r
                assign r_id = slot_id[i+1];
                assign r_pr = slot_pr[i+1];
            end

            spq_cell #(
                .QUEUE_DEPTH (QUEUE_DEPTH),
                .IDX         (i)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (cell_ctrl),
                .count      (count_reg),
                .left_stays (l_stays),
                .left_id    (l_id),
                .left_pr    (l_pr),
                .right_id   (r_id),
                .right_pr   (r_pr),
                .head_id    (slot_id[0]),
                .head_pr    (slot_pr[0]),
                .stays      (slot_stays[i]),
                .slot_id    (slot_id[i]),
                .slot_pr    (slot_pr[i])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        req_op_next     = req_op_reg;
        req_id_next     = req_id_reg;
        req_pr_next     = req_pr_reg;
        count_next      = count_reg;
        steps_next      = steps_reg;
        found_next      = found_reg;
        found_id_next   = found_id_reg;
        found_pr_next   = found_pr_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_pr_next     = out_pr_reg;
        out_empty_next  = out_empty_reg;
        cell_ctrl.cmd    = spq_pkg::CELL_HOLD;
        cell_ctrl.new_id = req_id_reg;
        cell_ctrl.new_pr = req_pr_reg;
        cell_ctrl.keep   = head_keep;

        unique case (state_reg)
            spq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    req_op_next = spq_pkg::spq_op_t'(s_tdata[1:0]);
                    req_id_next = s_tdata[9:2];
                    req_pr_next = s_tdata[17:10];
                    state_next  = spq_pkg::ST_WORK;
                end
            end
            spq_pkg::ST_WORK: begin
                if (out_free) begin
                    // Default result: miss, no data; override per operation.
                    out_valid_next  = 1'b1;
                    out_status_next = spq_pkg::STS_MISS;
                    out_id_next     = '0;
                    out_pr_next     = '0;
                    out_empty_next  = count_reg == '0;
                    state_next      = spq_pkg::ST_IDLE;
                    unique case (req_op_reg)
                        spq_pkg::OP_PUSH: begin
                            if (count_reg == CW'(QUEUE_DEPTH)) begin
                                out_status_next = spq_pkg::STS_FULL;
                            end else begin
                                cell_ctrl.cmd   = spq_pkg::CELL_PUSH;
                                count_next      = count_reg + 1'b1;
                                out_status_next = spq_pkg::STS_DONE;
                                out_empty_next  = 1'b0;
                            end
                        end
                        spq_pkg::OP_POP: begin
                            if (count_reg != '0) begin
                                cell_ctrl.cmd   = spq_pkg::CELL_SHIFT;
                                count_next      = count_reg - 1'b1;
                                out_status_next = spq_pkg::STS_DONE;
                                out_id_next     = slot_id[0];
                                out_pr_next     = slot_pr[0];
                                out_empty_next  = count_reg == CW'(1);
                            end
                        end
                        spq_pkg::OP_REMOVE: begin
                            if (count_reg != '0) begin
                                // Hold the result back and start the rotation.
                                out_valid_next = out_valid_reg && !m_tready;
                                out_status_next = out_status_reg;
                                out_id_next     = out_id_reg;
                                out_pr_next     = out_pr_reg;
                                out_empty_next  = out_empty_reg;
                                steps_next      = count_reg;
                                found_next      = 1'b0;
                                state_next      = spq_pkg::ST_ROT;
                            end
                        end
                        default: begin
                            out_status_next = spq_pkg::STS_MISS;
                        end
                    endcase
                end
            end
            spq_pkg::ST_ROT: begin
                // Advance one entry per cycle; hold the final step while the output is busy.
                if (steps_reg != CW'(1) || out_free) begin
                    cell_ctrl.cmd = spq_pkg::CELL_ROTATE;
                    steps_next    = steps_reg - 1'b1;
                    if (!head_keep) begin
                        count_next    = count_reg - 1'b1;
                        found_next    = 1'b1;
                        found_id_next = slot_id[0];
                        found_pr_next = slot_pr[0];
                    end
                    if (steps_reg == CW'(1)) begin
                        out_valid_next = 1'b1;
                        out_empty_next = count_next == '0;
                        state_next     = spq_pkg::ST_IDLE;
                        if (found_next) begin
                            out_status_next = spq_pkg::STS_DONE;
                            out_id_next     = found_id_next;
                            out_pr_next     = found_pr_next;
                        end else begin
                            out_status_next = spq_pkg::STS_MISS;
                            out_id_next     = '0;
                            out_pr_next     = '0;
                        end
                    end
                end
            end
            default: begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            steps_reg     <= '0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            steps_reg     <= steps_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_op_reg     <= req_op_next;
        req_id_reg     <= req_id_next;
        req_pr_reg     <= req_pr_next;
        found_id_reg   <= found_id_next;
        found_pr_reg   <= found_pr_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_pr_reg     <= out_pr_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_empty_reg, out_pr_reg, out_id_reg, out_status_reg};

    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(QUEUE_DEPTH),
        "entry count exceeds queue depth")
    `SPQ_ASSERT_NEXT(a_rot_no_grow, state_reg == spq_pkg::ST_ROT,
        count_reg <= $past(count_reg), "entry count grew during a remove")
    `SPQ_ASSERT_NEXT(a_push_grows, cell_ctrl.cmd == spq_pkg::CELL_PUSH,
        count_reg == $past(count_reg) + 1'b1, "push did not add exactly one entry")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the stable sorted priority queue core.
module tb_top;

    localparam int          DEPTH        = spq_pkg::QUEUE_DEPTH_DEF;
    localparam int          OP_W         = spq_pkg::OP_W;
    localparam int          ID_W         = spq_pkg::ID_W;
    localparam int          PR_W         = spq_pkg::PR_W;
    localparam int          S_TDATA_W    = spq_pkg::S_TDATA_W;
    localparam int          M_TDATA_W    = spq_pkg::M_TDATA_W;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;
    localparam int          HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int          IDLE_LIMIT   = 4000;  // cycles without any handshake
    localparam int          DRAIN_CYCLES = 40;    // longer than a full-row remove
    localparam int          RANDOM_ITEMS = 740;

    // Receiver stall patterns
    localparam int RX_FULL_RATE  = 0;
    localparam int RX_MOSTLY_ON  = 1;
    localparam int RX_MOSTLY_OFF = 2;
    localparam int RX_PERIODIC   = 3;

    typedef struct {
        spq_pkg::spq_status_t status;
        logic [ID_W-1:0]      task_id;
        logic [PR_W-1:0]      prio;
        logic                 queue_empty;
    } queue_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [1:0] operation, [9:2] task_id, [17:10] priority_req, [23:18] zero
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [1:0] status, [9:2] out_task_id, [17:10] out_priority, [18] queue_empty,
    // [23:19] zero
    logic [M_TDATA_W-1:0]   m_tdata;

    stable_priority_queue_remove_by_id_core #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the queue row, slot 0 the head
    logic [ID_W-1:0] shadow_id [DEPTH];
    logic [PR_W-1:0] shadow_pr [DEPTH];
    int              shadow_count = 0;

    queue_result_t   pending_results[$];
    int              error_count  = 0;
    int              burst_left   = 0;
    bit              hold_off_request = 0;

    // Coverage tallies for the closing summary
    int n_push = 0, n_full = 0, n_pop = 0, n_remove = 0, n_miss = 0, n_unused = 0;
    int peak_fill = 0;

    // Drop the entry at pos and close the gap towards the head.
    function automatic void shadow_take_out(int pos);
        for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_id[i] = shadow_id[i + 1];
            shadow_pr[i] = shadow_pr[i + 1];
        end
        shadow_count--;
    endfunction

    // Apply one request to the shadow row and work out the result it gives.
    function automatic queue_result_t queue_outcome(logic [1:0] op, logic [ID_W-1:0] id,
                                                    logic [PR_W-1:0] pr);
        queue_result_t r;
        int            pos;
        r.status  = spq_pkg::STS_MISS;
        r.task_id = '0;
        r.prio    = '0;
        case (op)
            spq_pkg::OP_PUSH: begin
                n_push++;
                if (shadow_count >= DEPTH) begin
                    r.status = spq_pkg::STS_FULL;
                    n_full++;
                end else begin
                    // stable insert: go behind every entry of equal or lower value
                    pos = 0;
                    while (pos < shadow_count && shadow_pr[pos] <= pr) pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_id[i] = shadow_id[i - 1];
                        shadow_pr[i] = shadow_pr[i - 1];
                    end
                    shadow_id[pos] = id;
                    shadow_pr[pos] = pr;
                    shadow_count++;
                    r.status = spq_pkg::STS_DONE;
                    if (shadow_count > peak_fill) peak_fill = shadow_count;
                end
            end
            spq_pkg::OP_POP: begin
                n_pop++;
                if (shadow_count > 0) begin
                    r.task_id = shadow_id[0];
                    r.prio    = shadow_pr[0];
                    r.status  = spq_pkg::STS_DONE;
                    shadow_take_out(0);
                end else begin
                    n_miss++;
                end
            end
            spq_pkg::OP_REMOVE: begin
                n_remove++;
                pos = -1;
                for (int i = 0; i < shadow_count && pos < 0; i++)
                    if (shadow_id[i] == id) pos = i;
                if (pos >= 0) begin
                    r.task_id = shadow_id[pos];
                    r.prio    = shadow_pr[pos];
                    r.status  = spq_pkg::STS_DONE;
                    shadow_take_out(pos);
                end else begin
                    n_miss++;
                end
            end
            default: n_unused++;
        endcase
        r.queue_empty = (shadow_count == 0);
        return r;
    endfunction

    // Priorities cluster on a few low values half the time, so ties are common.
    function automatic logic [PR_W-1:0] pick_priority();
        if ($urandom_range(0, 1) == 0) return PR_W'($urandom_range(0, 7));
        return PR_W'($urandom_range(0, 255));
    endfunction

    // Small ids half the time, so duplicates turn up.
    function automatic logic [ID_W-1:0] pick_task_id();
        if ($urandom_range(0, 1) == 0) return ID_W'($urandom_range(0, 15));
        return ID_W'($urandom_range(0, 255));
    endfunction

    // Offer one request, hold it until accepted, then record what it must give.
    // Requests go out in bursts; a random gap may open before each burst.
    task automatic send_request(input logic [1:0] op, input logic [ID_W-1:0] id,
                                input logic [PR_W-1:0] pr);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - ID_W - PR_W){1'b0}}, pr, id, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(queue_outcome(op, id, pr));
    endtask

    // Empty-queue misses, extremes, ties, the unused code and duplicate ids.
    task automatic test_directed();
        send_request(spq_pkg::OP_POP,    8'd0,   8'd0);
        send_request(spq_pkg::OP_REMOVE, 8'd0,   8'd0);
        send_request(OP_UNUSED,          8'd255, 8'd255);
        send_request(spq_pkg::OP_PUSH,   8'd10,  8'd128);
        send_request(spq_pkg::OP_PUSH,   8'd11,  8'd128);
        send_request(spq_pkg::OP_PUSH,   8'd12,  8'd128);
        send_request(spq_pkg::OP_PUSH,   8'd255, 8'd255);
        send_request(spq_pkg::OP_PUSH,   8'd0,   8'd0);
        send_request(spq_pkg::OP_PUSH,   8'd13,  8'd127);
        send_request(OP_UNUSED,          8'd5,   8'd9);
        send_request(spq_pkg::OP_REMOVE, 8'd11,  8'd0);   // middle of a run of ties
        send_request(spq_pkg::OP_REMOVE, 8'd99,  8'd0);   // id not present
        send_request(spq_pkg::OP_REMOVE, 8'd255, 8'd0);   // tail
        send_request(spq_pkg::OP_REMOVE, 8'd0,   8'd0);   // head
        send_request(spq_pkg::OP_PUSH,   8'd20,  8'd128); // goes behind the equal ones
        send_request(spq_pkg::OP_PUSH,   8'd10,  8'd200); // duplicate id
        send_request(spq_pkg::OP_REMOVE, 8'd10,  8'd0);   // must take the first of the two
        repeat (5) send_request(spq_pkg::OP_POP, 8'd0, 8'd0);
        send_request(spq_pkg::OP_POP,    8'd0,   8'd0);   // empty again
    endtask

    // Hold the receiver off while pushing past capacity, then drain past empty.
    task automatic test_fill_under_backpressure();
        hold_off_request = 1;
        repeat (DEPTH + 4) send_request(spq_pkg::OP_PUSH, pick_task_id(), pick_priority());
        repeat (DEPTH + 2) send_request(spq_pkg::OP_POP, pick_task_id(), pick_priority());
    endtask

    // Fill the row, then remove every entry by id in random order.
    task automatic test_remove_sweep();
        while (shadow_count < DEPTH)
            send_request(spq_pkg::OP_PUSH, ID_W'($urandom_range(0, 255)), pick_priority());
        while (shadow_count > 0)
            send_request(spq_pkg::OP_REMOVE,
                         shadow_id[$urandom_range(0, shadow_count - 1)], pick_priority());
    endtask

    // Mixed traffic in chunks, each with its own push bias so the fill level
    // wanders between empty and full.
    task automatic test_random_mix();
        int push_pct;
        int roll;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) push_pct = $urandom_range(20, 75);
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                send_request(spq_pkg::OP_PUSH, pick_task_id(), pick_priority());
            else if (roll < push_pct + 3)
                send_request(OP_UNUSED, pick_task_id(), pick_priority());
            else if (roll % 2 == 0)
                send_request(spq_pkg::OP_POP, pick_task_id(), pick_priority());
            else if (shadow_count != 0 && $urandom_range(0, 3) != 0)
                send_request(spq_pkg::OP_REMOVE,
                             shadow_id[$urandom_range(0, shadow_count - 1)], pick_priority());
            else
                send_request(spq_pkg::OP_REMOVE, pick_task_id(), pick_priority());
        end
    endtask

    // Receiver: switch between stall patterns, and honour a long hold-off.
    initial begin
        int mode;
        int phase_left;
        mode       = RX_FULL_RATE;
        phase_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_request = 0;
            end else begin
                if (phase_left == 0) begin
                    mode       = $urandom_range(RX_FULL_RATE, RX_PERIODIC);
                    phase_left = $urandom_range(16, 96);
                end
                phase_left--;
                case (mode)
                    RX_FULL_RATE:  m_tready <= 1'b1;
                    RX_MOSTLY_ON:  m_tready <= ($urandom_range(0, 3) != 0);
                    RX_MOSTLY_OFF: m_tready <= ($urandom_range(0, 3) == 0);
                    default:       m_tready <= (phase_left % 3 == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: m_tdata 0x%06h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[9:2] !== want.task_id) begin
                    $error("out_task_id: expected %0d, actual %0d",
                           want.task_id, m_tdata[9:2]);
                    error_count++;
                end
                if (m_tdata[17:10] !== want.prio) begin
                    $error("out_priority: expected %0d, actual %0d",
                           want.prio, m_tdata[17:10]);
                    error_count++;
                end
                if (m_tdata[18] !== want.queue_empty) begin
                    $error("queue_empty: expected %0d, actual %0d",
                           want.queue_empty, m_tdata[18]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long.
    always @(posedge aclk) begin
        int idle_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_fill_under_backpressure();
        test_remove_sweep();
        test_random_mix();
        s_tvalid <= 1'b0;

        // drain: wait for every result, then let the block settle
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end

        $display("Covered %0d pushes (%0d rejected as full), %0d pops, %0d removes,",
                 n_push, n_full, n_pop, n_remove);
        $display("%0d misses, %0d unused codes, peak fill %0d of %0d entries.",
                 n_miss, n_unused, peak_fill, DEPTH);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/stable_priority_queue_remove_by_id_core.sv
sim/tb_top.sv
